// ===== src/tlv8_pkg.sv =====
// tlv8_pkg: types, codes and constants shared by the tlv8 stream parser
// no dependencies; imported by the core, the queue and the top level
`default_nettype none

package tlv8_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2
  } phase_e;

  // result kind
  typedef enum logic [1:0] {
    KIND_VALUE     = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_END_OK    = 2'd2,
    KIND_END_TRUNC = 2'd3
  } kind_e;

  localparam logic [7:0]  AccWrap    = 8'd254;
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam int          QueueDepth = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  item_type;
    logic [7:0]  value_byte;
    logic        new_item;
    logic        fragment_last;
    logic [15:0] item_index;
    logic        last_result;
  } res_t;

  // up to two results produced by one input transaction
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

// ===== src/tlv8_stream_if.sv =====
// tlv8_stream_if: valid/ready channel carrying one payload per transaction
// payload type is a parameter; used with tlv8_pkg structs
`default_nettype none

interface tlv8_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/tlv8_stream_parser.sv =====
// tlv8_stream_parser: top level of the tlv8 record stream parser
// depends on tlv8_pkg, tlv8_stream_if, tlv8_core and tlv8_outq
//
// usage
//   in_i  : one raw buffer byte per transaction (in_byte, buffer_end)
//   out_o : one result per transaction (kind, item_type, value_byte,
//           new_item, fragment_last, item_index, last_result)
//   a byte causes zero, one or two results; last_result marks the final one
//   type bytes and nonzero length bytes give nothing unless flagged as end
//   results enter the queue when their byte is taken; out_o shows its head
//   throughput: one byte per cycle while results are drained as fast; a
//   byte with two results leaves the queue one extra result to drain
//   the parser state is updated in the cycle a byte is taken; results go
//   into a result queue of QueueDepth entries, and in_i.ready is high while
//   the queue has room for two results, so a stalled receiver backs up the
//   input after at most QueueDepth-1 pending results
//   reset clears the parser to "expect type byte" with no item open and
//   empties the queue; the end result of a buffer also returns the parser
//   to that state so the next byte starts a new buffer
`default_nettype none

module tlv8_stream_parser import tlv8_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tlv8_stream_if.sink   in_i,
  tlv8_stream_if.source out_o
);

  push_t push;
  logic  room;
  logic  in_acc;
  logic  out_acc;
  in_t   in_data;
  res_t  head;

  assign in_data    = in_i.data;
  assign in_i.ready = room;
  assign in_acc     = in_i.valid && room;

  // per-byte parser: state register plus next-state logic
  tlv8_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_acc),
    .in_i   (in_data),
    .push_o (push)
  );

  // result queue drives the output channel from registers
  tlv8_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_acc),
    .room_o  (room),
    .valid_o (out_o.valid),
    .head_o  (head)
  );

  assign out_o.data = head;
  assign out_acc    = out_o.valid && out_o.ready;

`ifndef SYNTH
  // nothing is pushed without an accepted byte
  a_push_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |-> (push.n == 2'd0))
    else $error("result pushed without an input transaction");

  // a flagged final byte always yields at least the end result
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data.buffer_end) |-> (push.n != 2'd0))
    else $error("final byte gave no end result");

  // a pair of results carries the last flag on the second only
  a_pair_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (push.r1.last_result && !push.r0.last_result))
    else $error("last_result misplaced in a result pair");

  // after a push, the output offers a result in the next cycle
  a_output_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |=> out_o.valid)
    else $error("pushed result not offered");
`endif

endmodule

`default_nettype wire

// ===== src/tlv8_core.sv =====
// tlv8_core: parser state register and per-byte next-state and result logic
// depends on tlv8_pkg
`default_nettype none

module tlv8_core import tlv8_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire in_t  in_i,
  output push_t     push_o
);

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  frag_type;
    logic [7:0]  bytes_left;
    logic [7:0]  prev_type;
    logic        have_item;
    logic [7:0]  acc_mod;
    logic        acc_ne;
    logic [15:0] item_count;
    logic        starting;
  } st_t;

  localparam st_t StReset = '{phase: PH_TYPE, default: '0};

  st_t st_q, st_d;

  function automatic st_t open_item(input st_t s, input logic [7:0] t);
    st_t o;
    o = s;
    if (s.have_item) begin
      if (s.item_count != CountMax) o.item_count = s.item_count + 16'd1;
    end else begin
      o.item_count = '0;
    end
    o.have_item = 1'b1;
    o.prev_type = t;
    o.acc_mod   = '0;
    o.acc_ne    = 1'b0;
    return o;
  endfunction

  always_comb begin
    st_t   s;
    res_t  r0, r1, endr;
    logic [1:0] n;
    logic  merge;
    s     = st_q;
    r0    = '0;
    r1    = '0;
    endr  = '0;
    n     = 2'd0;
    merge = st_q.have_item && (st_q.prev_type == st_q.frag_type) &&
            st_q.acc_ne && (st_q.acc_mod == 8'd0);

    case (st_q.phase)
      PH_LEN: begin
        if (in_i.in_byte == 8'd0) begin
          if (!merge) begin
            s = open_item(s, st_q.frag_type);
            r0.kind       = KIND_EMPTY;
            r0.item_type  = st_q.frag_type;
            r0.new_item   = 1'b1;
            r0.item_index = s.item_count;
            n             = 2'd1;
          end
          s.phase = PH_TYPE;
        end else begin
          if (!merge) s = open_item(s, st_q.frag_type);
          s.starting   = !merge;
          s.bytes_left = in_i.in_byte;
          s.phase      = PH_VAL;
        end
      end
      PH_VAL: begin
        r0.kind          = KIND_VALUE;
        r0.item_type     = st_q.frag_type;
        r0.value_byte    = in_i.in_byte;
        r0.new_item      = st_q.starting;
        r0.fragment_last = (st_q.bytes_left <= 8'd1);
        r0.item_index    = st_q.item_count;
        n                = 2'd1;
        s.starting       = 1'b0;
        s.acc_mod        = (st_q.acc_mod == AccWrap) ? 8'd0 : st_q.acc_mod + 8'd1;
        s.acc_ne         = 1'b1;
        s.bytes_left     = st_q.bytes_left - 8'd1;
        if (s.bytes_left == 8'd0) s.phase = PH_TYPE;
      end
      default: begin
        s.frag_type = in_i.in_byte;
        s.phase     = PH_LEN;
      end
    endcase

    if (in_i.buffer_end) begin
      endr.kind       = (s.phase == PH_TYPE) ? KIND_END_OK : KIND_END_TRUNC;
      endr.item_type  = s.have_item ? s.prev_type : 8'd0;
      endr.item_index = s.have_item ? s.item_count : 16'd0;
      if (n == 2'd0) r0 = endr;
      else           r1 = endr;
      n = n + 2'd1;
      s = StReset;
    end

    if (n == 2'd1) r0.last_result = 1'b1;
    if (n == 2'd2) r1.last_result = 1'b1;

    st_d      = en_i ? s : st_q;
    push_o.n  = en_i ? n : 2'd0;
    push_o.r0 = r0;
    push_o.r1 = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/tlv8_outq.sv =====
// tlv8_outq: small result queue, takes up to two results a cycle, gives one
// depends on tlv8_pkg
`default_nettype none

module tlv8_outq import tlv8_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  input  wire logic  pop_i,
  output logic       room_o,
  output logic       valid_o,
  output res_t       head_o
);

  // pointers wrap freely, so the depth is a power of two of at least two
  localparam int DEPTH = QueueDepth;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  res_t            mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q, cnt_d;

  // room for a worst-case push of two
  assign room_o  = (cnt_q <= CW'(DEPTH - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  assign cnt_d = cnt_q + CW'(push_i.n) - CW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + PW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(push_i.n);
      if (pop_i) rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire
